// File: src/tng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tng_pkg;

  localparam int OPCODE_W = 1;
  localparam int OFFSET_W = 2;
  localparam int DATA_W   = 8;
  localparam int SAMPLE_W = 14;
  localparam int PERIOD_W = 7;
  localparam int VOLUME_W = 3;
  localparam int MODE_W   = 2;
  localparam int NOISE_W  = 9;
  localparam int VOL_SHIFT = SAMPLE_W - VOLUME_W;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 1'b1;

  localparam logic [OFFSET_W-1:0] REG_PITCH   = 2'd1;
  localparam logic [OFFSET_W-1:0] REG_VOLMODE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_SILENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TONE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NOISE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd3;

  localparam logic [NOISE_W-1:0] NOISE_RELOAD = 9'h0f0;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [OFFSET_W-1:0] reg_offset;
    logic [DATA_W-1:0]   write_data;
  } item_t;

endpackage
`default_nettype wire

// File: src/tng_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tng_in_if import tng_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [OFFSET_W-1:0] reg_offset;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, output opcode, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input reg_offset, input write_data,
                output ready);
endinterface
`default_nettype wire

// File: src/tng_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tng_out_if import tng_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: src/tone_noise_sound_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | payload                          | beat
// in_ch    | in  | opcode, reg_offset, write_data   | valid & ready
// out_ch   | out | sample                           | valid & ready
//
// One item per cycle sustained unless a tick waits on a stalled output. An item is held in the input register,
// where the generator state updates; a tick then leaves its sample in the
// output register, which drives the output beat.
// Synchronous active-low reset restores the power-up generator state.
// A stalled output holds only a tick in the input register; writes pass on.
module tone_noise_sound_generator import tng_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tng_in_if.sink    in_ch,
  tng_out_if.source out_ch
);

  logic                item_valid_r;
  item_t               item_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] sample_r;

  logic [DATA_W-1:0]   pitch_r,  pitch_nxt;
  logic [VOLUME_W-1:0] volume_r, volume_nxt;
  logic [MODE_W-1:0]   mode_r,   mode_nxt;
  logic [PERIOD_W-1:0] count_r,  count_nxt;
  logic                tone_r,   tone_nxt;
  logic                noise_r,  noise_nxt;
  logic [NOISE_W-1:0]  shift_r,  shift_nxt;

  logic                is_tick;
  logic                item_go;
  logic                sel;
  logic [PERIOD_W:0]   count_inc;
  logic [SAMPLE_W-1:0] sample_nxt;

  assign is_tick      = (item_r.opcode == OP_TICK);
  assign item_go      = item_valid_r && (!is_tick || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !item_valid_r || item_go;
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample = sample_r;
  assign count_inc    = {1'b0, count_r} + {{PERIOD_W{1'b0}}, 1'b1};

  always_comb begin
    case (mode_r)
      MODE_TONE:  sel = tone_r;
      MODE_NOISE: sel = noise_r;
      MODE_BOTH:  sel = tone_r & noise_r;
      default:    sel = 1'b0;
    endcase
  end

  always_comb begin
    pitch_nxt  = pitch_r;
    volume_nxt = volume_r;
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    tone_nxt   = tone_r;
    noise_nxt  = noise_r;
    shift_nxt  = shift_r;
    sample_nxt = '0;
    if (!is_tick) begin
      if (item_r.reg_offset == REG_PITCH) begin
        pitch_nxt = item_r.write_data;
        if (item_r.write_data[PERIOD_W-1:0] == '0) begin
          shift_nxt = NOISE_RELOAD;
        end
      end else if (item_r.reg_offset == REG_VOLMODE) begin
        volume_nxt = item_r.write_data[VOLUME_W-1:0];
        mode_nxt   = item_r.write_data[VOLUME_W +: MODE_W];
        if (mode_nxt != mode_r) begin
          tone_nxt = 1'b0;
        end
      end
    end else if (pitch_r != '0) begin
      if (sel) begin
        sample_nxt = {volume_r, {VOL_SHIFT{1'b0}}};
      end
      if (count_inc >= {1'b0, pitch_r[PERIOD_W-1:0]}) begin
        count_nxt = '0;
        tone_nxt  = !tone_r;
        noise_nxt = shift_r[0];
        shift_nxt = {shift_r[0] ^ shift_r[4], shift_r[NOISE_W-1:1]};
      end else begin
        count_nxt = count_inc[PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      pitch_r      <= '0;
      volume_r     <= '0;
      mode_r       <= MODE_SILENT;
      count_r      <= '0;
      tone_r       <= 1'b1;
      noise_r      <= 1'b0;
      shift_r      <= NOISE_RELOAD;
    end else begin
      if (in_ch.ready) begin
        item_valid_r <= in_ch.valid;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (item_go) begin
        pitch_r  <= pitch_nxt;
        volume_r <= volume_nxt;
        mode_r   <= mode_nxt;
        count_r  <= count_nxt;
        tone_r   <= tone_nxt;
        noise_r  <= noise_nxt;
        shift_r  <= shift_nxt;
        if (is_tick) begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.opcode     <= in_ch.opcode;
      item_r.reg_offset <= in_ch.reg_offset;
      item_r.write_data <= in_ch.write_data;
    end
    if (item_go && is_tick) begin
      sample_r <= sample_nxt;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_tone_noise_sound_generator.sv
`timescale 1ns / 1ps
module tb_tone_noise_sound_generator;
  import tng_pkg::*;

  localparam logic [OFFSET_W-1:0] REG_IGNORED_LO = 2'd0;
  localparam logic [OFFSET_W-1:0] REG_IGNORED_HI = 2'd3;
  localparam int MAX_WAIT = 13;
  localparam int RANDOM_BEATS = 650;

  typedef struct {
    item_t       item;
    int unsigned gap;
    bit          drain;
  } stim_beat_t;

  logic clk;
  logic rst_n;

  tng_in_if  in_bus ();
  tng_out_if out_bus ();

  tone_noise_sound_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  stim_beat_t          pending_beats[$];
  logic [SAMPLE_W-1:0] samples_due[$];
  int unsigned         fail_count = 0;

  logic [DATA_W-1:0]   pitch_q  = '0;
  logic [VOLUME_W-1:0] volume_q = '0;
  logic [MODE_W-1:0]   mode_q   = MODE_SILENT;
  logic [PERIOD_W-1:0] count_q  = '0;
  logic                tone_q   = 1'b1;
  logic                noise_q  = 1'b0;
  logic [NOISE_W-1:0]  lfsr_q   = NOISE_RELOAD;

  task automatic step_generator(input item_t it);
    logic                sel;
    logic [PERIOD_W:0]   next_count;
    logic [MODE_W-1:0]   new_mode;
    logic                fb;
    logic [SAMPLE_W-1:0] sample;
    if (it.opcode == OP_WRITE) begin
      if (it.reg_offset == REG_PITCH) begin
        pitch_q = it.write_data;
        if (it.write_data[PERIOD_W-1:0] == '0) lfsr_q = NOISE_RELOAD;
      end else if (it.reg_offset == REG_VOLMODE) begin
        new_mode = it.write_data[4:3];
        volume_q = it.write_data[VOLUME_W-1:0];
        if (new_mode != mode_q) tone_q = 1'b0;
        mode_q = new_mode;
      end
    end else begin
      sample = '0;
      if (pitch_q != '0) begin
        case (mode_q)
          MODE_TONE:  sel = tone_q;
          MODE_NOISE: sel = noise_q;
          MODE_BOTH:  sel = tone_q & noise_q;
          default:    sel = 1'b0;
        endcase
        if (sel) sample = SAMPLE_W'(volume_q) << VOL_SHIFT;
        next_count = {1'b0, count_q} + (PERIOD_W+1)'(1);
        if (next_count >= {1'b0, pitch_q[PERIOD_W-1:0]}) begin
          fb      = lfsr_q[0] ^ lfsr_q[4];
          noise_q = lfsr_q[0];
          lfsr_q  = {fb, lfsr_q[NOISE_W-1:1]};
          tone_q  = ~tone_q;
          count_q = '0;
        end else begin
          count_q = next_count[PERIOD_W-1:0];
        end
      end
      samples_due.push_back(sample);
    end
  endtask

  task automatic push_beat(input logic [OPCODE_W-1:0] op, input logic [OFFSET_W-1:0] off,
                           input logic [DATA_W-1:0] data, input int unsigned gap,
                           input bit drain);
    stim_beat_t b;
    b.item.opcode     = op;
    b.item.reg_offset = off;
    b.item.write_data = data;
    b.gap             = gap;
    b.drain           = drain;
    pending_beats.push_back(b);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL tone_noise_sound_generator");
    $finish;
  end

  // driver
  stim_beat_t  beat;
  item_t       seen_item;
  int unsigned gap_left;
  int unsigned held_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.opcode     <= OP_WRITE;
      in_bus.reg_offset <= '0;
      in_bus.write_data <= '0;
      gap_left = 0;
      held_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        seen_item = {in_bus.opcode, in_bus.reg_offset, in_bus.write_data};
        step_generator(seen_item);
        gap_left = held_gap;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain && samples_due.size() != 0)) begin
          beat = pending_beats.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.opcode     <= beat.item.opcode;
          in_bus.reg_offset <= beat.item.reg_offset;
          in_bus.write_data <= beat.item.write_data;
          held_gap = beat.gap;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  logic [SAMPLE_W-1:0] want_sample;
  int unsigned         stall_left;
  int unsigned         stall_run;
  bit                  stall_active;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left   = 0;
      stall_run    = 0;
      stall_active = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (samples_due.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("unexpected sample %0d with nothing due", out_bus.sample);
        end else begin
          want_sample = samples_due.pop_front();
          if (out_bus.sample !== want_sample) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("sample mismatch: expected %0d got %0d", want_sample, out_bus.sample);
          end
        end
        if (stall_run == 0) begin
          stall_run    = $urandom_range(10, 60);
          stall_active = 1'($urandom_range(0, 1));
        end
        stall_run  = stall_run - 1;
        stall_left = stall_active ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  int unsigned        run_left;
  bit                 gaps_on;
  int unsigned        pick;
  int unsigned        gap;
  bit                 drain;
  logic [DATA_W-1:0]  pitch_byte;

  initial begin
    rst_n = 1'b0;

    // directed: reset silence, ignored offsets, zero period, modes, lowered period
    push_beat(OP_TICK,  REG_IGNORED_HI, 8'hff, 0, 1'b0);
    push_beat(OP_WRITE, REG_IGNORED_LO, 8'hff, 0, 1'b0);
    push_beat(OP_WRITE, REG_IGNORED_HI, 8'hff, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 0, 1'b0);
    push_beat(OP_WRITE, REG_VOLMODE,    8'hff, 0, 1'b0);
    push_beat(OP_WRITE, REG_PITCH,      8'h80, 0, 1'b0);
    push_beat(OP_TICK,  REG_PITCH,      8'h55, 0, 1'b0);
    push_beat(OP_TICK,  REG_VOLMODE,    8'haa, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_HI, 8'hff, 0, 1'b0);
    push_beat(OP_WRITE, REG_VOLMODE,    8'h0f, 3, 1'b0);
    push_beat(OP_WRITE, REG_PITCH,      8'h01, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 5, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 0, 1'b0);
    push_beat(OP_WRITE, REG_VOLMODE,    8'h10, 0, 1'b0);
    push_beat(OP_WRITE, REG_VOLMODE,    8'h17, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 0, 1'b0);
    push_beat(OP_WRITE, REG_PITCH,      8'h7f, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 13, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 0, 1'b0);
    push_beat(OP_WRITE, REG_PITCH,      8'h02, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_LO, 8'h00, 0, 1'b0);
    push_beat(OP_WRITE, REG_PITCH,      8'h00, 0, 1'b0);
    push_beat(OP_TICK,  REG_IGNORED_HI, 8'hff, 0, 1'b0);
    push_beat(OP_WRITE, REG_VOLMODE,    8'h00, 0, 1'b0);

    // random: mostly ticks with pitch and volume/mode changes mixed in
    run_left = 0;
    gaps_on  = 1'b0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      drain = 1'b0;
      if (run_left == 0) begin
        run_left = $urandom_range(40, 120);
        gaps_on  = 1'($urandom_range(0, 1));
        drain    = 1'b1;
      end
      run_left = run_left - 1;
      gap  = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        push_beat(OP_TICK, OFFSET_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)),
                  gap, drain);
      end else if (pick < 82) begin
        push_beat(OP_WRITE, REG_VOLMODE, DATA_W'($urandom_range(0, 255)), gap, drain);
      end else if (pick < 94) begin
        case ($urandom_range(0, 7))
          0:       pitch_byte = 8'h00;
          1:       pitch_byte = 8'h80;
          2, 3:    pitch_byte = DATA_W'($urandom_range(0, 255));
          default: pitch_byte = {1'($urandom_range(0, 1)), 7'($urandom_range(1, 8))};
        endcase
        push_beat(OP_WRITE, REG_PITCH, pitch_byte, gap, drain);
      end else begin
        push_beat(OP_WRITE, $urandom_range(0, 1) ? REG_IGNORED_HI : REG_IGNORED_LO,
                  DATA_W'($urandom_range(0, 255)), gap, drain);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_beats.size() != 0 || in_bus.valid || samples_due.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0 && samples_due.size() == 0) begin
      $display("PASS tone_noise_sound_generator");
    end else begin
      $display("FAIL tone_noise_sound_generator");
    end
    $finish;
  end

endmodule
